// ----- sv/mshu_pkg.sv -----
// mshu_pkg: shared types and constants for the moore stencil heat update block
// command and status structs between controller and datapath, window weight tables
// no dependencies
package mshu_pkg;

  localparam int TEMP_W     = 18;
  localparam int COND_W     = 16;
  localparam int GROW_W     = 16;
  localparam int CFG_W      = 9;
  localparam int CFG_DATA_W = 16;
  localparam int ENTRY_W    = TEMP_W + COND_W + 1;
  localparam int WEIGHT_W   = 9;
  localparam int LCM_W      = 12;
  localparam int TEMP_MAX   = 69632;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ROWS   = 2'd0,
    CFG_COLS   = 2'd1,
    CFG_GROWTH = 2'd2
  } cfg_idx_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic rd_center;
    logic latch_center;
    logic walk;
    logic den1;
    logic den2;
    logic den3;
    logic div_start;
    logic term;
    logic grow;
    logic final_load;
  } mshu_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic emit;
    logic walk_last;
    logic pipe_empty;
    logic nb_zero;
    logic div_done;
    logic out_full;
  } mshu_sts_t;

  // least common multiple of (d+2)^2 over d = 1..range
  function automatic int lcm_of(input int range);
    int res;
    case (range)
      1: res = 9;
      2: res = 144;
      default: res = 3600;
    endcase
    return res;
  endfunction

  // lcm / (d+2)^2 for a neighbor at chebyshev distance d
  function automatic int weight_of(input int range, input int d);
    int res;
    res = 1;
    if (range == 2) begin
      res = (d == 1) ? 16 : 9;
    end else if (range >= 3) begin
      res = (d == 1) ? 400 : ((d == 2) ? 225 : 144);
    end
    return res;
  endfunction

endpackage

// ----- sv/mshu_div.sv -----
// mshu_div: restoring divider, one quotient bit per cycle
// unsigned num / den, quotient replaces the numerator in its shift register
// depends on nothing
module mshu_div #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   rem_sh;

  // one shift and trial subtract per cycle
  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    rem_sh   = {rem_r[DEN_W-1:0], num_r[NUM_W-1]};
    if (start) begin
      num_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sh - {1'b0, den_r};
        num_nxt = {num_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign quo  = num_r;
  assign done = done_r;

endmodule

// ----- sv/mshu_dpath.sv -----
// mshu_dpath: datapath of the heat update block
// row store, frame counters, window product pipeline, scaling, growth and clamp
// depends on mshu_pkg and mshu_div
module mshu_dpath #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256,
  parameter int RANGE    = 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mshu_pkg::mshu_cmd_t             cmd,
  output mshu_pkg::mshu_sts_t             sts,
  input  logic signed [mshu_pkg::TEMP_W-1:0] in_cell_temperature,
  input  logic [mshu_pkg::COND_W-1:0]     in_cell_conductivity,
  input  logic                            in_cell_sign_neg,
  input  logic                            in_is_pad,
  input  logic                            cfg_wr,
  input  logic [1:0]                      cfg_index,
  input  logic [mshu_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_row,
  output logic [7:0]                      out_col,
  output logic signed [mshu_pkg::TEMP_W-1:0] out_new_temperature,
  output logic                            out_sign_neg,
  output logic                            out_frame_last
);
  import mshu_pkg::*;

  localparam int SLOTS  = 3 * RANGE + 1;
  localparam int SLW    = $clog2(SLOTS);
  localparam int DEPTH  = SLOTS * MAX_COLS;
  localparam int AW     = $clog2(DEPTH);
  localparam int RCW    = $clog2(MAX_ROWS + 1);
  localparam int CW     = $clog2(MAX_COLS + 1);
  localparam int RW     = $clog2(MAX_ROWS + RANGE + 2);
  localparam int DLW    = $clog2(RANGE * MAX_COLS + RANGE + 1);
  localparam int NB_MAX = (2 * RANGE + 1) * (2 * RANGE + 1) - 1;
  localparam int NBW    = $clog2(NB_MAX + 1);
  localparam int OW     = $clog2(RANGE + 1) + 1;
  localparam int DSW    = $clog2(RANGE + 1);
  localparam int PW     = RW + 2;
  localparam int P1W    = TEMP_W + COND_W + 2;
  localparam int P2W    = P1W + WEIGHT_W + 1;
  localparam int ACCW   = P2W + NBW;
  localparam int DW     = LCM_W + 2 * NBW;
  localparam int SUMW   = ((ACCW > DW + 15) ? ACCW : DW + 15) + 1;
  localparam int XW     = SUMW - 16;
  localparam int TRW    = XW + 1;
  localparam int GPW    = TRW + GROW_W + 1;
  localparam int RESW   = GPW + 2;
  localparam logic [LCM_W-1:0] LCM_V = LCM_W'(lcm_of(RANGE));
  localparam logic signed [RESW-1:0] HI_V = RESW'(TEMP_MAX);
  localparam logic signed [RESW-1:0] LO_V = -RESW'(TEMP_MAX);
  localparam logic signed [OW-1:0] RMAX = OW'(RANGE);
  localparam logic signed [OW-1:0] RMIN = -OW'(RANGE);

  // configuration
  logic [RCW-1:0]    rows_r;
  logic [CW-1:0]     cols_r;
  logic [GROW_W-1:0] grow_r;
  logic [31:0]       cfg_ext;

  // frame position
  logic [CW-1:0]  in_col_r, in_col_nxt, o_col_r, o_col_nxt;
  logic [RW-1:0]  in_row_r, in_row_nxt, o_row_r, o_row_nxt;
  logic [SLW-1:0] in_slot_r, in_slot_nxt, o_slot_r, o_slot_nxt;
  logic [DLW-1:0] p_cnt_r, p_cnt_nxt, delay_w;
  logic           started, emit, last_w, in_frame;

  // latched center cell
  logic [RW-1:0]       c_row_r;
  logic [CW-1:0]       c_col_r;
  logic [SLW-1:0]      c_slot_r;
  logic                last_r;
  logic signed [TEMP_W-1:0] tc_r;
  logic [COND_W-1:0]   kc_r;
  logic                sg_r;

  // row store
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_q, wr_data;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               rd_en;

  // window walk and product pipeline
  logic signed [OW-1:0] dy_r, dx_r;
  logic [NBW-1:0]       nb_r;
  logic signed [PW-1:0] nr, nc;
  logic [OW-1:0]        ady, adx;
  logic                 ingrid;
  int                   nslot;
  logic                 v0_r, v1_r, v2_r;
  logic [DSW-1:0]       d0_r, d1_r;
  logic signed [P1W-1:0] p1_r;
  logic signed [P2W-1:0] p2_r;
  logic signed [ACCW-1:0] acc_r;
  logic [WEIGHT_W-1:0]  w1;
  logic [COND_W:0]      ksum;

  // scaling and final steps
  logic [2*NBW-1:0]     nbsq_r;
  logic [DW-1:0]        den_r;
  logic [ACCW-1:0]      mag_r;
  logic                 neg_r;
  logic [SUMW-1:0]      sum_w;
  logic [XW-1:0]        x_r, quo;
  logic                 div_done;
  logic signed [TRW-1:0] term_r;
  logic signed [GPW-1:0] gp_r;
  logic [GPW-1:0]       gmag;
  logic [GPW:0]         grnd;
  logic signed [GPW:0]  term2;
  logic signed [RESW-1:0] res;
  logic signed [TEMP_W-1:0] res_sat;

  // output register
  logic out_valid_r;
  logic [7:0] orow_r, ocol_r;
  logic signed [TEMP_W-1:0] otemp_r;
  logic osign_r, olast_r;
  logic [31:0] row_ext, col_ext;

  function automatic logic [AW-1:0] addr_of(input logic [SLW-1:0] s, input logic [CW-1:0] c);
    return AW'(int'(s) * MAX_COLS + int'(c));
  endfunction

  // frame position and emit decision of the item being offered
  assign delay_w  = DLW'(RANGE * int'(cols_r) + RANGE);
  assign started  = (p_cnt_r == delay_w);
  assign emit     = started && ({1'b0, o_row_r} < {1'b0, RW'(rows_r)});
  assign last_w   = (o_row_r == RW'(rows_r - 1'b1)) && (o_col_r == cols_r - 1'b1);
  assign in_frame = ({1'b0, in_row_r} < {1'b0, RW'(rows_r)});

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    in_slot_nxt = in_slot_r;
    o_col_nxt   = o_col_r;
    o_row_nxt   = o_row_r;
    o_slot_nxt  = o_slot_r;
    p_cnt_nxt   = p_cnt_r;
    if (cfg_wr && (cfg_index == CFG_ROWS || cfg_index == CFG_COLS ||
                   cfg_index == CFG_GROWTH)) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      in_slot_nxt = '0;
      o_col_nxt   = '0;
      o_row_nxt   = '0;
      o_slot_nxt  = '0;
      p_cnt_nxt   = '0;
    end else if (cmd.accept) begin
      if (emit && last_w) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        in_slot_nxt = '0;
        o_col_nxt   = '0;
        o_row_nxt   = '0;
        o_slot_nxt  = '0;
        p_cnt_nxt   = '0;
      end else begin
        if (in_col_r == cols_r - 1'b1) begin
          in_col_nxt  = '0;
          in_row_nxt  = in_row_r + 1'b1;
          in_slot_nxt = (in_slot_r == SLW'(SLOTS - 1)) ? '0 : in_slot_r + 1'b1;
        end else begin
          in_col_nxt = in_col_r + 1'b1;
        end
        if (!started) begin
          p_cnt_nxt = p_cnt_r + 1'b1;
        end
        if (emit) begin
          if (o_col_r == cols_r - 1'b1) begin
            o_col_nxt  = '0;
            o_row_nxt  = o_row_r + 1'b1;
            o_slot_nxt = (o_slot_r == SLW'(SLOTS - 1)) ? '0 : o_slot_r + 1'b1;
          end else begin
            o_col_nxt = o_col_r + 1'b1;
          end
        end
      end
    end
  end

  // configuration registers, saturated to the grid limits
  always_comb begin
    cfg_ext = {{(32 - CFG_W){1'b0}}, cfg_data[CFG_W-1:0]};
    if (cfg_ext == 32'd0) begin
      cfg_ext = 32'd1;
    end
    if (cfg_index == CFG_ROWS && cfg_ext > 32'(MAX_ROWS)) begin
      cfg_ext = 32'(MAX_ROWS);
    end
    if (cfg_index == CFG_COLS && cfg_ext > 32'(MAX_COLS)) begin
      cfg_ext = 32'(MAX_COLS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= RCW'((MAX_ROWS < 256) ? MAX_ROWS : 256);
      cols_r    <= CW'((MAX_COLS < 256) ? MAX_COLS : 256);
      grow_r    <= '0;
      in_col_r  <= '0;
      in_row_r  <= '0;
      in_slot_r <= '0;
      o_col_r   <= '0;
      o_row_r   <= '0;
      o_slot_r  <= '0;
      p_cnt_r   <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ROWS:   rows_r <= cfg_ext[RCW-1:0];
          CFG_COLS:   cols_r <= cfg_ext[CW-1:0];
          CFG_GROWTH: grow_r <= cfg_data;
          default:    ;
        endcase
      end
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      in_slot_r <= in_slot_nxt;
      o_col_r   <= o_col_nxt;
      o_row_r   <= o_row_nxt;
      o_slot_r  <= o_slot_nxt;
      p_cnt_r   <= p_cnt_nxt;
    end
  end

  // row store write on accepted requests inside the frame, one read port
  assign wr_addr = addr_of(in_slot_r, in_col_r);
  assign wr_data = in_is_pad ? '0 :
                   {in_cell_sign_neg, in_cell_conductivity, in_cell_temperature};

  always_ff @(posedge clk) begin
    if (cmd.accept && in_frame) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // neighbor position, in-grid test and its row slot
  assign nr  = $signed({2'b00, c_row_r}) + PW'(dy_r);
  assign nc  = $signed({{(PW - CW){1'b0}}, c_col_r}) + PW'(dx_r);
  assign ady = dy_r[OW-1] ? -dy_r : dy_r;
  assign adx = dx_r[OW-1] ? -dx_r : dx_r;
  assign ingrid = !nr[PW-1] && (nr < $signed(PW'(rows_r))) &&
                  !nc[PW-1] && (nc < $signed(PW'(cols_r))) &&
                  !(dy_r == '0 && dx_r == '0);

  always_comb begin
    nslot = int'(c_slot_r) + int'(dy_r);
    if (nslot < 0) begin
      nslot = nslot + SLOTS;
    end
    if (nslot >= SLOTS) begin
      nslot = nslot - SLOTS;
    end
  end

  assign rd_en   = cmd.rd_center || (cmd.walk && ingrid);
  assign rd_addr = cmd.rd_center ? addr_of(c_slot_r, c_col_r) :
                   addr_of(SLW'(nslot), nc[CW-1:0]);

  // latch the emitted cell position at accept
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      c_row_r  <= o_row_r;
      c_col_r  <= o_col_r;
      c_slot_r <= o_slot_r;
      last_r   <= last_w;
    end
    if (cmd.latch_center) begin
      tc_r <= $signed(rd_q[TEMP_W-1:0]);
      kc_r <= rd_q[TEMP_W +: COND_W];
      sg_r <= rd_q[ENTRY_W-1];
    end
  end

  // window walk counters
  always_ff @(posedge clk) begin
    if (cmd.latch_center) begin
      dy_r <= RMIN;
      dx_r <= RMIN;
      nb_r <= '0;
    end else if (cmd.walk) begin
      if (dx_r == RMAX) begin
        dx_r <= RMIN;
        dy_r <= dy_r + 1'b1;
      end else begin
        dx_r <= dx_r + 1'b1;
      end
      if (ingrid) begin
        nb_r <= nb_r + 1'b1;
      end
    end
  end

  // product pipeline: read, temp times conductivity sum, times weight, accumulate
  assign ksum = {1'b0, rd_q[TEMP_W +: COND_W]} + {1'b0, kc_r};
  assign w1   = WEIGHT_W'(weight_of(RANGE, int'(d1_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= cmd.walk && ingrid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    d0_r <= (ady > adx) ? ady[DSW-1:0] : adx[DSW-1:0];
    d1_r <= d0_r;
    p1_r <= $signed(rd_q[TEMP_W-1:0]) * $signed({1'b0, ksum});
    p2_r <= p1_r * $signed({1'b0, w1});
    if (cmd.latch_center) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACCW'(p2_r);
    end
  end

  // denominator lcm * n^2, magnitude with half denominator, drop 16 fraction bits
  assign sum_w = SUMW'(mag_r) + (SUMW'(den_r) << 15);

  always_ff @(posedge clk) begin
    if (cmd.den1) begin
      nbsq_r <= (2*NBW)'(nb_r) * (2*NBW)'(nb_r);
    end
    if (cmd.den2) begin
      den_r <= DW'(nbsq_r) * DW'(LCM_V);
      neg_r <= acc_r[ACCW-1];
      mag_r <= acc_r[ACCW-1] ? ACCW'(-acc_r) : ACCW'(acc_r);
    end
    if (cmd.den3) begin
      x_r <= sum_w[SUMW-1:16];
    end
  end

  mshu_div #(
    .NUM_W (XW),
    .DEN_W (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (x_r),
    .den   (den_r),
    .quo   (quo),
    .done  (div_done)
  );

  // signed neighbor term and growth product
  always_ff @(posedge clk) begin
    if (cmd.term) begin
      if (nb_r == '0) begin
        term_r <= '0;
      end else if (neg_r ^ sg_r) begin
        term_r <= -$signed({1'b0, quo});
      end else begin
        term_r <= $signed({1'b0, quo});
      end
    end
    if (cmd.grow) begin
      gp_r <= term_r * $signed({1'b0, grow_r});
    end
  end

  // growth rounding, add center temperature, saturate
  assign gmag = gp_r[GPW-1] ? GPW'(-gp_r) : GPW'(gp_r);
  assign grnd = ({1'b0, gmag} + (GPW+1)'(128)) >> 8;

  always_comb begin
    if (grow_r != '0) begin
      term2 = gp_r[GPW-1] ? -$signed(grnd) : $signed(grnd);
    end else begin
      term2 = (GPW+1)'(term_r);
    end
    res = RESW'(tc_r) + RESW'(term2);
    if (res > HI_V) begin
      res_sat = TEMP_W'(TEMP_MAX);
    end else if (res < LO_V) begin
      res_sat = -TEMP_W'(TEMP_MAX);
    end else begin
      res_sat = res[TEMP_W-1:0];
    end
  end

  // output register
  assign row_ext = 32'(c_row_r);
  assign col_ext = 32'(c_col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.final_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.final_load) begin
      orow_r  <= row_ext[7:0];
      ocol_r  <= col_ext[7:0];
      otemp_r <= res_sat;
      osign_r <= sg_r;
      olast_r <= last_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_row             = orow_r;
  assign out_col             = ocol_r;
  assign out_new_temperature = otemp_r;
  assign out_sign_neg        = osign_r;
  assign out_frame_last      = olast_r;

  // status back to the controller
  assign sts.emit       = emit;
  assign sts.walk_last  = (dy_r == RMAX) && (dx_r == RMAX);
  assign sts.pipe_empty = !v0_r && !v1_r && !v2_r;
  assign sts.nb_zero    = (nb_r == '0);
  assign sts.div_done   = div_done;
  assign sts.out_full   = out_valid_r && out_stall;

endmodule

// ----- sv/mshu_ctrl.sv -----
// mshu_ctrl: controller state machine of the heat update block
// sequences store write, window walk, division, growth and output load
// depends on mshu_pkg
module mshu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output mshu_pkg::mshu_cmd_t cmd,
  input  mshu_pkg::mshu_sts_t sts
);
  import mshu_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_CENTER = 13'b0000000000010,
    S_CWAIT  = 13'b0000000000100,
    S_WALK   = 13'b0000000001000,
    S_DRAIN  = 13'b0000000010000,
    S_DEN1   = 13'b0000000100000,
    S_DEN2   = 13'b0000001000000,
    S_DEN3   = 13'b0000010000000,
    S_DIV    = 13'b0000100000000,
    S_DIVW   = 13'b0001000000000,
    S_TERM   = 13'b0010000000000,
    S_GROW   = 13'b0100000000000,
    S_FINAL  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && sts.emit) begin
          state_nxt = S_CENTER;
        end
      end
      S_CENTER: begin
        cmd.rd_center = 1'b1;
        state_nxt     = S_CWAIT;
      end
      S_CWAIT: begin
        cmd.latch_center = 1'b1;
        state_nxt        = S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = S_DEN1;
        end
      end
      S_DEN1: begin
        cmd.den1  = 1'b1;
        state_nxt = S_DEN2;
      end
      S_DEN2: begin
        cmd.den2  = 1'b1;
        state_nxt = S_DEN3;
      end
      S_DEN3: begin
        cmd.den3  = 1'b1;
        state_nxt = sts.nb_zero ? S_TERM : S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          state_nxt = S_TERM;
        end
      end
      S_TERM: begin
        cmd.term  = 1'b1;
        state_nxt = S_GROW;
      end
      S_GROW: begin
        cmd.grow  = 1'b1;
        state_nxt = S_FINAL;
      end
      S_FINAL: begin
        if (!sts.out_full) begin
          cmd.final_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ----- sv/moore_stencil_heat_update.sv -----
// moore_stencil_heat_update: top level, controller plus datapath
// depends on mshu_pkg, mshu_ctrl, mshu_dpath (which holds mshu_div)
//
// Cells arrive in raster order; each request inside the frame is stored in a
// row store of 3*RANGE+1 rows and, once the Moore window of the cell
// RANGE*cols+RANGE positions back is complete, that cell's next temperature is
// computed and placed in an output register. A request that completes no window
// is taken without stalling the input; one that does stalls it while its window
// is walked, its sum is scaled and its result waits for a free output register:
// the window is walked one neighbor per cycle over the single read port of the
// row store, and the scaling division runs one quotient bit per cycle (XW is
// 35 bits at the default limits); a cell with no neighbors skips the division.
// A new request is taken while a finished result still waits in the output
// register. Configuration writes are taken only while no request is in progress
// and none is offered, and restart the frame; after a frame, RANGE rows plus
// RANGE pad cells flush out the last results.
module moore_stencil_heat_update #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256,
  parameter int RANGE    = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mshu_pkg::TEMP_W-1:0]  in_cell_temperature,
  input  logic [mshu_pkg::COND_W-1:0]         in_cell_conductivity,
  input  logic                                in_cell_sign_neg,
  input  logic                                in_is_pad,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_row,
  output logic [7:0]                          out_col,
  output logic signed [mshu_pkg::TEMP_W-1:0]  out_new_temperature,
  output logic                                out_sign_neg,
  output logic                                out_frame_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [mshu_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mshu_pkg::*;

  mshu_cmd_t cmd;
  mshu_sts_t sts;

  // writes only between requests
  assign cfg_ready = !in_stall && !in_valid;

  mshu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  mshu_dpath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .RANGE    (RANGE)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_cell_temperature  (in_cell_temperature),
    .in_cell_conductivity (in_cell_conductivity),
    .in_cell_sign_neg     (in_cell_sign_neg),
    .in_is_pad            (in_is_pad),
    .cfg_wr               (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_row              (out_row),
    .out_col              (out_col),
    .out_new_temperature  (out_new_temperature),
    .out_sign_neg         (out_sign_neg),
    .out_frame_last       (out_frame_last)
  );

endmodule

// ----- sv/mshu_chk.sv -----
// mshu_chk: port level checks for the heat update block, bound to the top level
// depends on mshu_pkg
module mshu_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [7:0]                          out_row,
  input logic [7:0]                          out_col,
  input logic signed [mshu_pkg::TEMP_W-1:0]  out_new_temperature,
  input logic                                out_sign_neg,
  input logic                                out_frame_last
);
  import mshu_pkg::*;

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_new_temperature) &&
      $stable(out_row) && $stable(out_col) && $stable(out_frame_last) &&
      $stable(out_sign_neg))
    else $error("stalled result changed");

  // results stay within the saturation range
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_new_temperature <= TEMP_W'(TEMP_MAX)) &&
      (out_new_temperature >= -TEMP_W'(TEMP_MAX)))
    else $error("result outside saturation range");

  // a fresh result never appears in the cycle after the block was idle and empty
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !in_stall && !in_valid |=> !out_valid)
    else $error("result without a request");

endmodule

bind moore_stencil_heat_update mshu_chk u_chk (.*);

// ----- test/moore_stencil_heat_update_test.sv -----
// moore_stencil_heat_update_test: self-checking bench for the moore stencil heat update block
// drives raster cells and pad flushes, predicts each updated cell, checks the result stream
// depends on mshu_pkg and moore_stencil_heat_update
`timescale 1ns / 1ps

module moore_stencil_heat_update_test;
  import mshu_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int DRAIN_WAIT   = 120;
  localparam int SLOT_COUNT   = 4;
  localparam int ITEM_GOAL    = 600;

  typedef struct packed {
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [17:0] temp;
    logic               sign_neg;
    logic               last;
  } heat_res_t;

  typedef struct {
    logic signed [17:0] temp;
    logic [15:0]        cond;
    logic               sign_neg;
    logic               pad;
    bit                 typed;
    logic signed [17:0] typed_temp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [17:0] in_cell_temperature = '0;
  logic [15:0] in_cell_conductivity = '0;
  logic in_cell_sign_neg = 1'b0;
  logic in_is_pad = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_row;
  logic [7:0] out_col;
  logic signed [17:0] out_new_temperature;
  logic out_sign_neg;
  logic out_frame_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = CFG_ROWS;
  logic [15:0] cfg_data = '0;

  // predictor state
  int         grid_rows = 256;
  int         grid_cols = 256;
  int         grow_q88 = 0;
  int         row_pos = 0;
  int         col_pos = 0;
  int         cell_temp [SLOT_COUNT][256];
  int         cell_cond [SLOT_COUNT][256];
  bit         cell_neg [SLOT_COUNT][256];

  heat_res_t  pending_updates[$];
  int         mismatches = 0;
  int         cycles = 0;
  int         sent = 0;
  bit         calm = 1'b0;
  bit         hold_start = 1'b0;
  int         hold_left = 0;
  int         burst_left = 0;

  stim_row_t  directed [25];

  moore_stencil_heat_update u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cell_temperature(in_cell_temperature),
    .in_cell_conductivity(in_cell_conductivity),
    .in_cell_sign_neg(in_cell_sign_neg), .in_is_pad(in_is_pad),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_row(out_row), .out_col(out_col),
    .out_new_temperature(out_new_temperature),
    .out_sign_neg(out_sign_neg), .out_frame_last(out_frame_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // round to nearest, halves away from zero
  function automatic longint round_away(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  // only the low nine bits size the grid
  function automatic int fit_dim(logic [15:0] v);
    int x;
    x = int'(v[8:0]);
    if (x == 0) x = 1;
    if (x > 256) x = 256;
    return x;
  endfunction

  // store one cell, return the update of the cell whose window it completes
  function automatic bit heat_update(logic signed [17:0] t, logic [15:0] k, logic neg,
                                     logic pad, output heat_res_t r);
    int total;
    int lag;
    int p;
    int q;
    int cr;
    int cc;
    int nr;
    int nc;
    int nb;
    longint acc;
    longint term;
    longint res;
    longint kc;
    bit hit;
    total = grid_rows * grid_cols;
    lag = grid_cols + 1;
    p = row_pos * grid_cols + col_pos;
    hit = 1'b0;
    r = '0;
    if (p < total) begin
      cell_temp[row_pos % SLOT_COUNT][col_pos] = pad ? 0 : int'(t);
      cell_cond[row_pos % SLOT_COUNT][col_pos] = pad ? 0 : int'(k);
      cell_neg[row_pos % SLOT_COUNT][col_pos] = pad ? 1'b0 : neg;
    end
    if (p >= lag && p - lag < total) begin
      q = p - lag;
      cr = q / grid_cols;
      cc = q % grid_cols;
      kc = cell_cond[cr % SLOT_COUNT][cc];
      acc = 0;
      nb = 0;
      term = 0;
      // range one: every neighbor weight is lcm / 9 = 1
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          nr = cr + dy;
          nc = cc + dx;
          if ((dx != 0 || dy != 0) && nr >= 0 && nr < grid_rows && nc >= 0 && nc < grid_cols)
          begin
            nb++;
            acc += longint'(cell_temp[nr % SLOT_COUNT][nc]) *
                   (longint'(cell_cond[nr % SLOT_COUNT][nc]) + kc);
          end
        end
      end
      if (nb != 0) begin
        term = round_away(acc, 64'd9 * nb * nb * 65536);
        if (cell_neg[cr % SLOT_COUNT][cc]) term = -term;
        if (grow_q88 != 0) term = round_away(term * grow_q88, 256);
      end
      res = cell_temp[cr % SLOT_COUNT][cc] + term;
      if (res > TEMP_MAX) res = TEMP_MAX;
      if (res < -TEMP_MAX) res = -TEMP_MAX;
      r.row = cr[7:0];
      r.col = cc[7:0];
      r.temp = res[17:0];
      r.sign_neg = cell_neg[cr % SLOT_COUNT][cc];
      r.last = (q == total - 1);
      hit = 1'b1;
      if (q == total - 1) begin
        row_pos = 0;
        col_pos = 0;
        return hit;
      end
    end
    col_pos++;
    if (col_pos >= grid_cols) begin
      col_pos = 0;
      row_pos++;
    end
    return hit;
  endfunction

  // offer one cell request, with an optional gap first
  task automatic send_cell(logic signed [17:0] t, logic [15:0] k, logic neg, logic pad,
                           bit typed = 1'b0, logic signed [17:0] typed_temp = '0);
    heat_res_t r;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cell_temperature <= t;
    in_cell_conductivity <= k;
    in_cell_sign_neg <= neg;
    in_is_pad <= pad;
    do @(posedge clk); while (in_stall);
    sent++;
    if (heat_update(t, k, neg, pad, r)) begin
      if (typed) r.temp = typed_temp;
      pending_updates.push_back(r);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ROWS: grid_rows = fit_dim(value);
      CFG_COLS: grid_cols = fit_dim(value);
      default: grow_q88 = int'(value);
    endcase
    row_pos = 0;
    col_pos = 0;
    @(posedge clk);
  endtask

  task automatic random_cell(output logic signed [17:0] t, output logic [15:0] k);
    if ($urandom_range(0, 7) == 0) t = 18'($urandom);
    else t = 18'(int'($urandom_range(0, 139264)) - 69632);
    if ($urandom_range(0, 7) == 0) k = 16'($urandom);
    else k = 16'($urandom_range(0, 32768));
  endtask

  // result side stall: long hold-offs on request, else random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_start) begin
      hold_start = 1'b0;
      hold_left = 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each accepted result with the oldest pending update
  always @(posedge clk) begin
    heat_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result row %0d col %0d temp %0d", out_row, out_col,
                   out_new_temperature);
      end else begin
        e = pending_updates.pop_front();
        if (out_row !== e.row || out_col !== e.col || out_new_temperature !== e.temp ||
            out_sign_neg !== e.sign_neg || out_frame_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp r%0d c%0d t%0d s%0d l%0d got r%0d c%0d t%0d s%0d l%0d",
                     e.row, e.col, e.temp, e.sign_neg, e.last, out_row, out_col,
                     out_new_temperature, out_sign_neg, out_frame_last);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic signed [17:0] t;
    logic [15:0] k;
    int frame;
    int flush;
    int cells;

    // 1x1 frames: result is the saturated centre temperature
    for (int i = 0; i < 12; i++) directed[i] = '{18'sd0, 16'd0, 1'b0, 1'b1, 1'b0, 18'sd0};
    directed[0] = '{18'sd69632, 16'd65535, 1'b0, 1'b0, 1'b0, 18'sd0};
    directed[2].typed = 1'b1;
    directed[2].typed_temp = 18'sd69632;
    directed[3] = '{18'sh1FFFF, 16'd0, 1'b0, 1'b0, 1'b0, 18'sd0};
    directed[5].typed = 1'b1;
    directed[5].typed_temp = 18'sd69632;
    directed[6] = '{18'sh20000, 16'd32768, 1'b1, 1'b0, 1'b0, 18'sd0};
    directed[8].typed = 1'b1;
    directed[8].typed_temp = -18'sd69632;
    directed[9] = '{-18'sd5, 16'd1, 1'b1, 1'b0, 1'b0, 18'sd0};
    directed[11].typed = 1'b1;
    directed[11].typed_temp = -18'sd5;
    // 3x3 frame with extremes and a pad inside, then flush
    for (int i = 12; i < 25; i++) begin
      directed[i] = '{(i % 2) ? 18'sd69632 : -18'sd69632, (i % 3 == 0) ? 16'hFFFF : 16'd32768,
                      i[0] ^ i[1], 1'b0, 1'b0, 18'sd0};
    end
    directed[16].pad = 1'b1;
    for (int i = 21; i < 25; i++) directed[i].pad = 1'b1;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_ROWS, 16'd0);
    write_reg(CFG_COLS, 16'd1);
    for (int i = 0; i < 25; i++) begin
      if (i == 12) begin
        wait_drained();
        write_reg(CFG_ROWS, 16'd3);
        write_reg(CFG_COLS, 16'd3);
        write_reg(CFG_GROWTH, 16'd511);
      end
      send_cell(directed[i].temp, directed[i].cond, directed[i].sign_neg, directed[i].pad,
                directed[i].typed, directed[i].typed_temp);
    end

    // random frames of random shapes
    frame = 0;
    while (sent < ITEM_GOAL) begin
      wait_drained();
      if (frame == 4) begin
        write_reg(CFG_ROWS, 16'd300);
        write_reg(CFG_COLS, 16'd1);
      end else if (frame == 8) begin
        // upper data bits are ignored by the size registers
        write_reg(CFG_ROWS, 16'hFE02);
        write_reg(CFG_COLS, 16'h0E03);
      end else begin
        write_reg(CFG_ROWS, 16'($urandom_range(1, 8)));
        write_reg(CFG_COLS, 16'($urandom_range(1, 8)));
      end
      if ($urandom_range(0, 2) != 0) write_reg(CFG_GROWTH, $urandom_range(0, 1) ? 16'd0 :
                                                          16'($urandom_range(0, 65535)));
      if (frame == 2) hold_start = 1'b1;
      if (sent > ITEM_GOAL - 80) calm = 1'b1;
      cells = grid_rows * grid_cols;
      // a few frames are cut short and abandoned
      if (frame > 9 && $urandom_range(0, 9) == 0) cells = $urandom_range(1, cells);
      for (int c = 0; c < cells; c++) begin
        random_cell(t, k);
        send_cell(t, k, 1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
      end
      if (cells == grid_rows * grid_cols) begin
        // flush: cells past the frame only advance the stream
        flush = grid_cols + 1;
        for (int c = 0; c < flush; c++) begin
          random_cell(t, k);
          send_cell(t, k, 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
        end
      end
      frame++;
    end

    in_valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/mshu_pkg.sv
sv/mshu_div.sv
sv/mshu_dpath.sv
sv/mshu_ctrl.sv
sv/moore_stencil_heat_update.sv
sv/mshu_chk.sv
test/moore_stencil_heat_update_test.sv
